// ----- rtl/wsd_pkg.sv -----
// wsd_pkg: shared types and constants for the websocket frame deframer
// used by wsd_parser and websocket_frame_deframer; no dependencies
`timescale 1ns / 1ps

package wsd_pkg;

	localparam logic [6:0] LEN_EXT16 = 7'd126;
	localparam logic [6:0] LEN_EXT64 = 7'd127;
	localparam logic [2:0] EXT16_BYTES_M1 = 3'd1;
	localparam logic [2:0] EXT64_BYTES_M1 = 3'd7;
	localparam logic [2:0] KEY_BYTES_M1 = 3'd3;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       has_data;
		logic [3:0] frame_opcode;
		logic       fin_bit;
		logic       frame_end;
	} result_t;

endpackage

// ----- rtl/wsd_parser.sv -----
// wsd_parser: frame header state machine, length tracking and payload unmasking
// one byte per step; result is combinational from current state and byte; uses wsd_pkg
`timescale 1ns / 1ps

module wsd_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [7:0]        in_byte,
	output logic              res_valid,
	output wsd_pkg::result_t  res
);

	typedef enum logic [2:0] {
		PH_HDR0    = 3'd0,
		PH_HDR1    = 3'd1,
		PH_EXTLEN  = 3'd2,
		PH_MASK    = 3'd3,
		PH_PAYLOAD = 3'd4
	} phase_t;

	phase_t      phase_q, phase_d;
	logic        fin_q, fin_d;
	logic [3:0]  opcode_q, opcode_d;
	logic        masked_q, masked_d;
	logic [63:0] rem_q, rem_d;
	logic [2:0]  hdr_cnt_q, hdr_cnt_d;
	logic [31:0] key_q, key_d;
	logic [1:0]  key_idx_q, key_idx_d;

	logic [6:0]  len7;
	logic [63:0] rem_shift;
	logic [31:0] key_shift;
	logic [7:0]  key_byte;
	logic [63:0] rem_dec;
	logic        last_payload;

	assign len7         = in_byte[6:0];
	assign rem_shift    = {rem_q[55:0], in_byte};
	assign key_shift    = {key_q[23:0], in_byte};
	assign key_byte     = masked_q ? key_q[{~key_idx_q, 3'b000} +: 8] : 8'h00;
	assign rem_dec      = (rem_q == 64'd0) ? 64'd0 : rem_q - 64'd1;
	assign last_payload = (rem_dec == 64'd0);

	always_comb begin
		phase_d   = phase_q;
		fin_d     = fin_q;
		opcode_d  = opcode_q;
		masked_d  = masked_q;
		rem_d     = rem_q;
		hdr_cnt_d = hdr_cnt_q;
		key_d     = key_q;
		key_idx_d = key_idx_q;
		res_valid = 1'b0;
		res.data_byte    = 8'h00;
		res.has_data     = 1'b0;
		res.frame_opcode = opcode_q;
		res.fin_bit      = fin_q;
		res.frame_end    = 1'b1;
		unique case (phase_q)
			PH_HDR1: begin
				masked_d = in_byte[7];
				if (len7 == wsd_pkg::LEN_EXT16) begin
					rem_d     = 64'd0;
					phase_d   = PH_EXTLEN;
					hdr_cnt_d = wsd_pkg::EXT16_BYTES_M1;
				end else if (len7 == wsd_pkg::LEN_EXT64) begin
					rem_d     = 64'd0;
					phase_d   = PH_EXTLEN;
					hdr_cnt_d = wsd_pkg::EXT64_BYTES_M1;
				end else begin
					rem_d = {57'd0, len7};
					key_d = 32'd0;
					if (in_byte[7]) begin
						phase_d   = PH_MASK;
						hdr_cnt_d = wsd_pkg::KEY_BYTES_M1;
					end else begin
						key_idx_d = 2'd0;
						if (len7 == 7'd0) begin
							phase_d   = PH_HDR0;
							res_valid = 1'b1;
						end else begin
							phase_d = PH_PAYLOAD;
						end
					end
				end
			end
			PH_EXTLEN: begin
				rem_d = rem_shift;
				if (hdr_cnt_q == 3'd0) begin
					key_d = 32'd0;
					if (masked_q) begin
						phase_d   = PH_MASK;
						hdr_cnt_d = wsd_pkg::KEY_BYTES_M1;
					end else begin
						key_idx_d = 2'd0;
						if (rem_shift == 64'd0) begin
							phase_d   = PH_HDR0;
							res_valid = 1'b1;
						end else begin
							phase_d = PH_PAYLOAD;
						end
					end
				end else begin
					hdr_cnt_d = hdr_cnt_q - 3'd1;
				end
			end
			PH_MASK: begin
				key_d = key_shift;
				if (hdr_cnt_q == 3'd0) begin
					key_idx_d = 2'd0;
					if (rem_q == 64'd0) begin
						phase_d   = PH_HDR0;
						res_valid = 1'b1;
					end else begin
						phase_d = PH_PAYLOAD;
					end
				end else begin
					hdr_cnt_d = hdr_cnt_q - 3'd1;
				end
			end
			PH_PAYLOAD: begin
				key_idx_d     = key_idx_q + 2'd1;
				rem_d         = rem_dec;
				res_valid     = 1'b1;
				res.data_byte = in_byte ^ key_byte;
				res.has_data  = 1'b1;
				res.frame_end = last_payload;
				if (last_payload) begin
					phase_d = PH_HDR0;
				end
			end
			default: begin
				fin_d    = in_byte[7];
				opcode_d = in_byte[3:0];
				phase_d  = PH_HDR1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HDR0;
			fin_q     <= 1'b0;
			opcode_q  <= 4'd0;
			masked_q  <= 1'b0;
			rem_q     <= 64'd0;
			hdr_cnt_q <= 3'd0;
			key_q     <= 32'd0;
			key_idx_q <= 2'd0;
		end else if (step) begin
			phase_q   <= phase_d;
			fin_q     <= fin_d;
			opcode_q  <= opcode_d;
			masked_q  <= masked_d;
			rem_q     <= rem_d;
			hdr_cnt_q <= hdr_cnt_d;
			key_q     <= key_d;
			key_idx_q <= key_idx_d;
		end
	end

endmodule

// ----- rtl/websocket_frame_deframer.sv -----
// websocket_frame_deframer: top level with input register, parser and result register
// instantiates wsd_parser; uses wsd_pkg
// a result is registered in the output register after its byte has passed the input register and the parser
// throughput: one byte per cycle while out_ready keeps up, set by the single-pass parser between the registers
// in_ready falls only while a result waits in the output register and the input stage is full
// reset: asynchronous, parser returns to waiting for a first header byte, all stages empty
`timescale 1ns / 1ps

module websocket_frame_deframer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] data_byte,
	output logic       has_data,
	output logic [3:0] frame_opcode,
	output logic       fin_bit,
	output logic       frame_end
);

	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             advance;
	logic             step;
	logic             res_valid;
	wsd_pkg::result_t res;
	logic             out_valid_q;
	wsd_pkg::result_t out_q;

	// input stage moves on whenever the result register can take a request
	assign advance  = !out_valid_q || out_ready;
	assign step     = valid_s1 && advance;
	assign in_ready = !valid_s1 || advance;

	wsd_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.in_byte   (byte_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				out_valid_q <= step && res_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= in_byte;
		end
		if (step && res_valid) begin
			out_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign data_byte    = out_q.data_byte;
	assign has_data     = out_q.has_data;
	assign frame_opcode = out_q.frame_opcode;
	assign fin_bit      = out_q.fin_bit;
	assign frame_end    = out_q.frame_end;

endmodule

// ----- verif/websocket_frame_deframer_test.sv -----
// websocket_frame_deframer_test: self-checking bench for the websocket frame deframer
// byte requests come from a queue through a bursty driver, results are checked in a stalling
// monitor against an in-bench frame parser; depends on wsd_pkg and websocket_frame_deframer
`timescale 1ns / 1ps

module websocket_frame_deframer_test;

	typedef enum logic [2:0] {
		WAIT_HDR0 = 3'd0,
		WAIT_HDR1 = 3'd1,
		EXT_LEN   = 3'd2,
		MASK_KEY  = 3'd3,
		PAYLOAD   = 3'd4
	} parse_phase_t;

	typedef enum int {
		LEN_FORM7,
		LEN_FORM16,
		LEN_FORM64
	} len_form_t;

	localparam int IDLE_LIMIT = 5000;
	localparam int END_CYCLES = 8;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] in_byte = 8'h00;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] data_byte;
	logic       has_data;
	logic [3:0] frame_opcode;
	logic       fin_bit;
	logic       frame_end;

	websocket_frame_deframer uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_byte(in_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.data_byte(data_byte),
		.has_data(has_data),
		.frame_opcode(frame_opcode),
		.fin_bit(fin_bit),
		.frame_end(frame_end)
	);

	logic [7:0]        pending_bytes[$];
	wsd_pkg::result_t  expected_results[$];
	int                errors = 0;
	int                queued_total = 0;

	// parser state mirrored in the bench
	parse_phase_t pr_phase = WAIT_HDR0;
	logic         pr_fin = 1'b0;
	logic [3:0]   pr_opcode = 4'h0;
	logic         pr_masked = 1'b0;
	logic [63:0]  pr_remaining = 64'd0;
	logic [2:0]   pr_hdr_count = 3'd0;
	logic [31:0]  pr_key = 32'd0;
	logic [1:0]   pr_key_index = 2'd0;

	initial begin
		forever #5 clk = ~clk;
	end

	task automatic queue_byte(input logic [7:0] b);
		pending_bytes = {pending_bytes, b};
		queued_total++;
	endtask

	task automatic push_result(input logic [7:0] d, input logic hd, input logic fe);
		wsd_pkg::result_t r;
		r.data_byte = d;
		r.has_data = hd;
		r.frame_opcode = pr_opcode;
		r.fin_bit = pr_fin;
		r.frame_end = fe;
		expected_results = {expected_results, r};
	endtask

	task automatic finish_header();
		pr_key_index = 2'd0;
		if (pr_remaining == 64'd0) begin
			pr_phase = WAIT_HDR0;
			push_result(8'h00, 1'b0, 1'b1);
		end else begin
			pr_phase = PAYLOAD;
		end
	endtask

	task automatic finish_length();
		pr_key = 32'd0;
		if (pr_masked) begin
			pr_phase = MASK_KEY;
			pr_hdr_count = wsd_pkg::KEY_BYTES_M1;
		end else begin
			finish_header();
		end
	endtask

	task automatic deframe_byte(input logic [7:0] b);
		logic [31:0] shifted;
		logic [7:0]  k;
		case (pr_phase)
			WAIT_HDR1: begin
				pr_masked = b[7];
				pr_remaining = 64'd0;
				if (b[6:0] == wsd_pkg::LEN_EXT16) begin
					pr_phase = EXT_LEN;
					pr_hdr_count = wsd_pkg::EXT16_BYTES_M1;
				end else if (b[6:0] == wsd_pkg::LEN_EXT64) begin
					pr_phase = EXT_LEN;
					pr_hdr_count = wsd_pkg::EXT64_BYTES_M1;
				end else begin
					pr_remaining = {57'd0, b[6:0]};
					finish_length();
				end
			end
			EXT_LEN: begin
				pr_remaining = {pr_remaining[55:0], b};
				if (pr_hdr_count == 3'd0)
					finish_length();
				else
					pr_hdr_count = pr_hdr_count - 3'd1;
			end
			MASK_KEY: begin
				pr_key = {pr_key[23:0], b};
				if (pr_hdr_count == 3'd0)
					finish_header();
				else
					pr_hdr_count = pr_hdr_count - 3'd1;
			end
			PAYLOAD: begin
				shifted = pr_key >> (8 * (3 - pr_key_index));
				k = pr_masked ? shifted[7:0] : 8'h00;
				pr_key_index = pr_key_index + 2'd1;
				if (pr_remaining != 64'd0)
					pr_remaining = pr_remaining - 64'd1;
				if (pr_remaining == 64'd0)
					pr_phase = WAIT_HDR0;
				push_result(b ^ k, 1'b1, pr_remaining == 64'd0);
			end
			default: begin
				pr_fin = b[7];
				pr_opcode = b[3:0];
				pr_phase = WAIT_HDR1;
			end
		endcase
	endtask

	// frame with random key and payload; nbytes may be short of len to leave it open
	task automatic queue_frame(input logic [7:0] b0, input logic masked, input len_form_t form,
			input logic [63:0] len, input int nbytes);
		queue_byte(b0);
		case (form)
			LEN_FORM16: begin
				queue_byte({masked, wsd_pkg::LEN_EXT16});
				queue_byte(len[15:8]);
				queue_byte(len[7:0]);
			end
			LEN_FORM64: begin
				queue_byte({masked, wsd_pkg::LEN_EXT64});
				for (int i = 7; i >= 0; i--)
					queue_byte(len[8*i +: 8]);
			end
			default: queue_byte({masked, len[6:0]});
		endcase
		if (masked)
			for (int i = 0; i < 4; i++)
				queue_byte(8'($urandom));
		for (int i = 0; i < nbytes; i++)
			queue_byte(8'($urandom));
	endtask

	task automatic wait_drained();
		while (pending_bytes.size() != 0 || in_valid || expected_results.size() != 0)
			@(posedge clk);
	endtask

	// driver: bursts of requests with random gaps
	int burst_left = 1;
	int gap_left = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_byte <= 8'h00;
			burst_left <= 1;
			gap_left <= 0;
		end else begin
			if (in_valid && in_ready)
				deframe_byte(in_byte);
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					in_valid <= 1'b0;
					gap_left <= gap_left - 1;
				end else if (pending_bytes.size() != 0) begin
					in_valid <= 1'b1;
					in_byte <= pending_bytes.pop_front();
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 30);
						gap_left <= ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 8);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver stall pattern, reshaped at random each time rx_age wraps
	int rx_count = 0;
	int rx_period = 1;
	int rx_low = 0;
	int rx_age = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			rx_count <= 0;
			rx_period <= 1;
			rx_low <= 0;
			rx_age <= 0;
		end else begin
			out_ready <= (rx_count >= rx_low);
			if (rx_age == 63) begin
				rx_age <= 0;
				rx_count <= 0;
				rx_period <= $urandom_range(1, 8);
				rx_low <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
			end else begin
				rx_age <= rx_age + 1;
				rx_count <= (rx_count + 1 >= rx_period + rx_low) ? 0 : rx_count + 1;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		wsd_pkg::result_t exp_r;
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				$error("unexpected result: data_byte %0h has_data %0b", data_byte, has_data);
				errors++;
			end else begin
				exp_r = expected_results.pop_front();
				if (data_byte !== exp_r.data_byte) begin
					$error("data_byte expected %0h actual %0h", exp_r.data_byte, data_byte);
					errors++;
				end
				if (has_data !== exp_r.has_data) begin
					$error("has_data expected %0b actual %0b", exp_r.has_data, has_data);
					errors++;
				end
				if (frame_opcode !== exp_r.frame_opcode) begin
					$error("frame_opcode expected %0h actual %0h", exp_r.frame_opcode,
						frame_opcode);
					errors++;
				end
				if (fin_bit !== exp_r.fin_bit) begin
					$error("fin_bit expected %0b actual %0b", exp_r.fin_bit, fin_bit);
					errors++;
				end
				if (frame_end !== exp_r.frame_end) begin
					$error("frame_end expected %0b actual %0b", exp_r.frame_end, frame_end);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles without any accepted request or result
	int idle_cycles = 0;

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("websocket_frame_deframer verification failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		int r;
		int len;
		logic masked;
		logic [7:0] hdr0;
		len_form_t form;
		repeat (2) @(posedge clk);
		#1 arst_n = 1'b1;

		// empty text frame
		queue_frame(8'h81, 1'b0, LEN_FORM7, 64'd0, 0);
		// reserved bits set, opcode 15, masked empty frame
		queue_frame(8'h7F, 1'b1, LEN_FORM7, 64'd0, 0);
		// masked binary frame with byte extremes; key index wraps
		queue_byte(8'h82);
		queue_byte(8'h85);
		queue_byte(8'h00);
		queue_byte(8'hFF);
		queue_byte(8'hAA);
		queue_byte(8'h55);
		queue_byte(8'h00);
		queue_byte(8'hFF);
		queue_byte(8'h5A);
		queue_byte(8'hA5);
		queue_byte(8'hFF);
		// non-minimal 16-bit zero length, ping
		queue_frame(8'h09, 1'b0, LEN_FORM16, 64'd0, 0);
		// 64-bit length of one, close
		queue_frame(8'h88, 1'b0, LEN_FORM64, 64'd1, 1);
		wait_drained();

		r = 0;
		while (queued_total < 600 && r < 1000) begin
			hdr0 = 8'($urandom);
			masked = 1'($urandom_range(0, 1));
			form = LEN_FORM7;
			case ($urandom_range(0, 99)) inside
				[0:49]:  len = $urandom_range(1, 8);
				[50:59]: len = 0;
				[60:71]: len = $urandom_range(9, 63);
				[72:76]: len = $urandom_range(64, 125);
				[77:87]: begin
					form = LEN_FORM16;
					len = $urandom_range(0, 40);
				end
				default: begin
					form = LEN_FORM64;
					len = $urandom_range(0, 30);
				end
			endcase
			// whole payload follows the header
			queue_frame(hdr0, masked, form, 64'(len), len);
			r++;
			if (r == 20)
				wait_drained();
		end
		wait_drained();

		// 64-bit length with its top bit set; the frame stays open to the end
		queue_frame(8'h02, 1'b1, LEN_FORM64, 64'h8000_0000_0000_0005, 6);
		wait_drained();
		repeat (END_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("websocket_frame_deframer verification clean");
		else
			$display("websocket_frame_deframer verification failed");
		$finish;
	end

endmodule
